// File: src/rc4v_pkg.sv
// Shared types, codes and a helper function for the RC4-variant stream decryptor.
`timescale 1ns / 1ps
`default_nettype none

package rc4v_pkg;

    // Command codes carried by an input transaction.
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_BUILD  = 2'd1;
    localparam logic [1:0] CMD_DECODE = 2'd2;

    // Status codes returned with every result.
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_INVALID    = 2'd1;
    localparam logic [1:0] STATUS_BUILD_FAIL = 2'd2;

    // Register index of the seed register (byte address bit 2 selects the register).
    localparam logic REG_MAGIC_SEED = 1'b0;

    // Table geometry.
    localparam int TABLE_AW = 8;

    // One input transaction.
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] key_index;
        logic [7:0] value;
        logic       chunk_start;
    } cmd_item_t;

    // One result transaction.
    typedef struct packed {
        logic [7:0] data_out;
        logic [1:0] status;
    } res_item_t;

    // Port controls of one table memory.
    typedef struct packed {
        logic                we;
        logic [TABLE_AW-1:0] waddr;
        logic [7:0]          wdata;
        logic [TABLE_AW-1:0] raddr;
    } ram_ctrl_t;

    // Rotate a byte right by one bit.
    function automatic logic [7:0] rotr1(input logic [7:0] v);
        rotr1 = {v[0], v[7:1]};
    endfunction

endpackage

`default_nettype wire

// File: src/rc4v_ram.sv
// Generic single-write, single-read memory with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rc4v_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; a read at the written address returns old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/rc4v_apb.sv
// APB register file holding the seed register of the key schedule.
`timescale 1ns / 1ps
`default_nettype none

module rc4v_apb (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [7:0]  seed
);

    logic [7:0] seed_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == rc4v_pkg::REG_MAGIC_SEED);

    // Seed register write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 8'd0;
        end
        else if (wr_en)
        begin
            seed_reg <= pwdata[7:0];
        end
    end

    // Read back; addresses beyond the register read as zero.
    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == rc4v_pkg::REG_MAGIC_SEED)
        begin
            prdata = {24'd0, seed_reg};
        end
    end

    assign seed = seed_reg;

endmodule

`default_nettype wire

// File: src/rc4v_ctrl.sv
// Sequencer that runs key loads, the key schedule, table copies and keystream decode.
`timescale 1ns / 1ps
`default_nettype none

module rc4v_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_stall,
    input  wire rc4v_pkg::cmd_item_t  cmd_item,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output rc4v_pkg::res_item_t       res_item,
    input  wire logic [7:0]           seed,
    output rc4v_pkg::ram_ctrl_t       key_ctrl,
    input  wire logic [7:0]           key_rdata,
    output rc4v_pkg::ram_ctrl_t       base_ctrl,
    input  wire logic [7:0]           base_rdata,
    output rc4v_pkg::ram_ctrl_t       work_ctrl,
    input  wire logic [7:0]           work_rdata
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT,
        ST_RDKEY,
        ST_HASH,
        ST_CHECK,
        ST_KEY0,
        ST_TP,
        ST_TJ,
        ST_WJ,
        ST_CRD,
        ST_CWR,
        ST_DI,
        ST_DJ,
        ST_DWI,
        ST_DWJ,
        ST_DRD,
        ST_DOUT,
        ST_DONE
    } state_t;

    state_t     state_reg;
    logic [7:0] p_reg;
    logic [7:0] k_reg;
    logic [7:0] bj_reg;
    logic [7:0] hash_reg;
    logic [7:0] accum_reg;
    logic       first_reg;
    logic [7:0] kb_reg;
    logic [7:0] ta_reg;
    logic [7:0] tb_reg;
    logic [7:0] value_reg;
    logic [7:0] idx_i_reg;
    logic [7:0] idx_j_reg;
    logic       table_valid_reg;
    logic [7:0] res_data_reg;
    logic [1:0] res_status_reg;
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic [1:0] out_status_reg;

    logic       accept;
    logic [7:0] hash_rot;
    logic [7:0] kb_prod;
    logic [7:0] accum_next;
    logic       key_match;
    logic [7:0] bj_next;
    logic [7:0] chk_byte;
    logic [7:0] idx_i_inc;
    logic [7:0] idx_j_next;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;

    // Key schedule datapath: hash rotation, checksum term and shuffle index.
    assign hash_rot   = rc4v_pkg::rotr1(hash_reg);
    assign kb_prod    = {key_rdata[6:0], 1'b0} + (hash_rot[0] ? key_rdata : 8'd0);
    assign accum_next = first_reg ? (accum_reg + kb_prod) : accum_reg;
    assign key_match  = (hash_rot == key_rdata);
    assign bj_next    = bj_reg + (hash_reg ^ kb_reg) + base_rdata;
    // No key byte follows the last position, so the check compares against zero there.
    assign chk_byte   = (k_reg == 8'hff) ? 8'd0 : key_rdata;

    // Decode datapath.
    assign idx_i_inc  = idx_i_reg + 8'd1;
    assign idx_j_next = idx_j_reg + work_rdata;

    // Memory port controls for each state.
    always_comb
    begin
        key_ctrl.we     = accept && (cmd_item.command == rc4v_pkg::CMD_LOAD);
        key_ctrl.waddr  = cmd_item.key_index;
        key_ctrl.wdata  = cmd_item.value;
        key_ctrl.raddr  = k_reg;

        base_ctrl.we    = 1'b0;
        base_ctrl.waddr = p_reg;
        base_ctrl.wdata = p_reg;
        base_ctrl.raddr = p_reg;

        work_ctrl.we    = 1'b0;
        work_ctrl.waddr = idx_i_reg;
        work_ctrl.wdata = work_rdata;
        work_ctrl.raddr = idx_i_inc;

        unique case (state_reg)
            ST_INIT:
            begin
                base_ctrl.we = 1'b1;
            end
            ST_HASH:
            begin
                // Next key byte for the first-match check, or key[0] after a restart.
                key_ctrl.raddr = first_reg ? (k_reg + 8'd1) : 8'd0;
            end
            ST_CHECK:
            begin
                key_ctrl.raddr = 8'd0;
            end
            ST_TP:
            begin
                base_ctrl.raddr = bj_next;
            end
            ST_TJ:
            begin
                base_ctrl.we    = 1'b1;
                base_ctrl.wdata = base_rdata;
            end
            ST_WJ:
            begin
                base_ctrl.we    = 1'b1;
                base_ctrl.waddr = bj_reg;
                base_ctrl.wdata = ta_reg;
            end
            ST_CWR:
            begin
                work_ctrl.we    = 1'b1;
                work_ctrl.waddr = p_reg;
                work_ctrl.wdata = base_rdata;
            end
            ST_DJ:
            begin
                work_ctrl.raddr = idx_j_next;
            end
            ST_DWI:
            begin
                work_ctrl.we = 1'b1;
            end
            ST_DWJ:
            begin
                work_ctrl.we    = 1'b1;
                work_ctrl.waddr = idx_j_reg;
                work_ctrl.wdata = ta_reg;
            end
            ST_DRD:
            begin
                work_ctrl.raddr = ta_reg + tb_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer state, working registers and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            table_valid_reg <= 1'b0;
            idx_i_reg       <= 8'd0;
            idx_j_reg       <= 8'd0;
            out_valid_reg   <= 1'b0;
            p_reg           <= 8'd0;
            k_reg           <= 8'd0;
            bj_reg          <= 8'd0;
            hash_reg        <= 8'd0;
            accum_reg       <= 8'd0;
            first_reg       <= 1'b1;
            kb_reg          <= 8'd0;
            ta_reg          <= 8'd0;
            tb_reg          <= 8'd0;
            value_reg       <= 8'd0;
            res_data_reg    <= 8'd0;
            res_status_reg  <= rc4v_pkg::STATUS_OK;
            out_data_reg    <= 8'd0;
            out_status_reg  <= rc4v_pkg::STATUS_OK;
        end
        else
        begin
            // The output register empties when its result is taken, unless a new
            // result moves in at the same edge.
            if (out_valid_reg && !res_stall && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        value_reg      <= cmd_item.value;
                        res_data_reg   <= 8'd0;
                        res_status_reg <= rc4v_pkg::STATUS_OK;
                        p_reg          <= 8'd0;
                        state_reg      <= ST_DONE;
                        if (cmd_item.command == rc4v_pkg::CMD_BUILD)
                        begin
                            state_reg <= ST_INIT;
                        end
                        else if (cmd_item.command == rc4v_pkg::CMD_DECODE)
                        begin
                            if (!table_valid_reg)
                            begin
                                res_status_reg <= rc4v_pkg::STATUS_INVALID;
                            end
                            else if (cmd_item.chunk_start)
                            begin
                                state_reg <= ST_CRD;
                            end
                            else
                            begin
                                state_reg <= ST_DI;
                            end
                        end
                    end
                end

                // Base table starts as the identity.
                ST_INIT:
                begin
                    p_reg <= p_reg + 8'd1;
                    if (p_reg == 8'hff)
                    begin
                        k_reg     <= 8'd0;
                        bj_reg    <= 8'd0;
                        hash_reg  <= seed;
                        accum_reg <= seed;
                        first_reg <= 1'b1;
                        state_reg <= ST_RDKEY;
                    end
                end

                ST_RDKEY:
                begin
                    state_reg <= ST_HASH;
                end

                ST_HASH:
                begin
                    if (key_match && first_reg)
                    begin
                        accum_reg <= accum_next;
                        state_reg <= ST_CHECK;
                    end
                    else if (key_match)
                    begin
                        hash_reg  <= rc4v_pkg::rotr1(seed);
                        k_reg     <= 8'd0;
                        state_reg <= ST_KEY0;
                    end
                    else
                    begin
                        hash_reg  <= hash_rot;
                        accum_reg <= accum_next;
                        kb_reg    <= key_rdata;
                        state_reg <= ST_TP;
                    end
                end

                ST_CHECK:
                begin
                    if (accum_reg != chk_byte)
                    begin
                        res_status_reg <= rc4v_pkg::STATUS_BUILD_FAIL;
                        state_reg      <= ST_DONE;
                    end
                    else
                    begin
                        hash_reg  <= rc4v_pkg::rotr1(seed);
                        k_reg     <= 8'd0;
                        first_reg <= 1'b0;
                        state_reg <= ST_KEY0;
                    end
                end

                ST_KEY0:
                begin
                    kb_reg    <= key_rdata;
                    state_reg <= ST_TP;
                end

                ST_TP:
                begin
                    ta_reg    <= base_rdata;
                    bj_reg    <= bj_next;
                    state_reg <= ST_TJ;
                end

                ST_TJ:
                begin
                    state_reg <= ST_WJ;
                end

                ST_WJ:
                begin
                    p_reg <= p_reg + 8'd1;
                    k_reg <= k_reg + 8'd1;
                    if (p_reg == 8'hff)
                    begin
                        table_valid_reg <= 1'b1;
                        state_reg       <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_RDKEY;
                    end
                end

                // Chunk start: copy the base table into the working table.
                ST_CRD:
                begin
                    state_reg <= ST_CWR;
                end

                ST_CWR:
                begin
                    p_reg <= p_reg + 8'd1;
                    if (p_reg == 8'hff)
                    begin
                        idx_i_reg <= 8'd0;
                        idx_j_reg <= 8'd0;
                        state_reg <= ST_DI;
                    end
                    else
                    begin
                        state_reg <= ST_CRD;
                    end
                end

                // Keystream step: read W[i], read W[j], swap, read W[W[i] + W[j]].
                ST_DI:
                begin
                    idx_i_reg <= idx_i_inc;
                    state_reg <= ST_DJ;
                end

                ST_DJ:
                begin
                    ta_reg    <= work_rdata;
                    idx_j_reg <= idx_j_next;
                    state_reg <= ST_DWI;
                end

                ST_DWI:
                begin
                    tb_reg    <= work_rdata;
                    state_reg <= ST_DWJ;
                end

                ST_DWJ:
                begin
                    state_reg <= ST_DRD;
                end

                ST_DRD:
                begin
                    state_reg <= ST_DOUT;
                end

                ST_DOUT:
                begin
                    res_data_reg <= value_reg ^ work_rdata;
                    state_reg    <= ST_DONE;
                end

                // Hand the result to the output register once it is free.
                ST_DONE:
                begin
                    if (!out_valid_reg || !res_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_data_reg   <= res_data_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid         = out_valid_reg;
    assign res_item.data_out = out_data_reg;
    assign res_item.status   = out_status_reg;

endmodule

`default_nettype wire

// File: src/rc4_variant_stream_decrypt.sv
// Top level of the RC4-variant stream decryptor: register port, sequencer and table memories.
`timescale 1ns / 1ps
`default_nettype none

// An RC4-style stream decryptor with a custom key schedule. Every input transaction
// (load key byte, build table, decode byte) yields exactly one result transaction. The
// block works on one transaction at a time and stalls its input until that transaction's
// result has entered the output register; a result waiting there does not block the next
// input. All three tables sit in single-port-read memories with a registered read. A decode
// with chunk_start first copies the base table into the working table, reading and then
// writing each entry. A build first sets up the identity table and then shuffles one table
// position after another, with an extra step where a later hash match restarts the key and
// more at the first match, whose checksum is checked; a failed check ends the build early.
// The seed register at byte address 0
// must only be written while the block is idle.
module rc4_variant_stream_decrypt (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_stall,
    input  wire rc4v_pkg::cmd_item_t  cmd_item,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output rc4v_pkg::res_item_t       res_item,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);

    logic [7:0]          seed;
    rc4v_pkg::ram_ctrl_t key_ctrl;
    rc4v_pkg::ram_ctrl_t base_ctrl;
    rc4v_pkg::ram_ctrl_t work_ctrl;
    logic [7:0]          key_rdata;
    logic [7:0]          base_rdata;
    logic [7:0]          work_rdata;

    // Configuration registers.
    rc4v_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .seed    (seed)
    );

    // Sequencer.
    rc4v_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_item   (cmd_item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item),
        .seed       (seed),
        .key_ctrl   (key_ctrl),
        .key_rdata  (key_rdata),
        .base_ctrl  (base_ctrl),
        .base_rdata (base_rdata),
        .work_ctrl  (work_ctrl),
        .work_rdata (work_rdata)
    );

    // Key store.
    rc4v_ram #(
        .WIDTH (8),
        .DEPTH (256)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_ctrl.we),
        .waddr (key_ctrl.waddr),
        .wdata (key_ctrl.wdata),
        .raddr (key_ctrl.raddr),
        .rdata (key_rdata)
    );

    // Base permutation built by the key schedule.
    rc4v_ram #(
        .WIDTH (8),
        .DEPTH (256)
    ) u_base_ram (
        .clk   (clk),
        .we    (base_ctrl.we),
        .waddr (base_ctrl.waddr),
        .wdata (base_ctrl.wdata),
        .raddr (base_ctrl.raddr),
        .rdata (base_rdata)
    );

    // Working permutation used for keystream generation.
    rc4v_ram #(
        .WIDTH (8),
        .DEPTH (256)
    ) u_work_ram (
        .clk   (clk),
        .we    (work_ctrl.we),
        .waddr (work_ctrl.waddr),
        .wdata (work_ctrl.wdata),
        .raddr (work_ctrl.raddr),
        .rdata (work_rdata)
    );

endmodule

`default_nettype wire

// File: bench/rc4_variant_stream_decrypt_tb.sv
// Self-checking testbench for the RC4-variant stream decryptor.
`timescale 1ns / 1ps

module rc4_variant_stream_decrypt_tb;

    localparam int CYCLE_LIMIT     = 3_000_000;
    localparam int RESET_CYCLES    = 5;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_ITEMS     = 320;
    localparam int MAX_REPORTS     = 40;
    localparam int NO_MATCH        = -1;
    localparam int ITEM_W          = $bits(rc4v_pkg::cmd_item_t);
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [2:0] SEED_ADDR  = {rc4v_pkg::REG_MAGIC_SEED, 2'b00};

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_stall;
    rc4v_pkg::cmd_item_t cmd_item;
    logic                res_valid;
    logic                res_stall = 1'b0;
    rc4v_pkg::res_item_t res_item;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // Mirror of the block state, advanced once per accepted input transaction.
    logic [7:0] seed_reg = 8'h00;
    logic [7:0] key_mem   [256];
    logic [7:0] base_perm [256];
    logic [7:0] work_perm [256];
    logic       perm_ready = 1'b0;
    logic       work_ready = 1'b0;
    logic [7:0] ks_i = 8'h00;
    logic [7:0] ks_j = 8'h00;

    rc4v_pkg::res_item_t pending_results [$];

    int    error_count      = 0;
    int    item_count       = 0;
    int    load_count       = 0;
    int    build_count      = 0;
    int    build_pass_count = 0;
    int    decode_count     = 0;
    int    restart_count    = 0;
    int    send_idle_pct    = 0;
    int    recv_stall_pct   = 0;
    bit    hold_off_pending = 1'b0;
    longint cycle_count     = 0;

    rc4_variant_stream_decrypt dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run the custom key schedule on the mirrored key store; returns 0 on a failed check.
    function automatic bit run_key_schedule();
        logic [7:0] hash;
        logic [7:0] accum;
        logic [7:0] kb;
        logic [7:0] nxt;
        logic [7:0] jj;
        logic [7:0] tmp;
        bit         first;
        int         k;
        int         p;
        for (p = 0; p < 256; p++)
            base_perm[p] = p[7:0];
        hash  = seed_reg;
        accum = seed_reg;
        first = 1'b1;
        k     = 0;
        jj    = 8'h00;
        for (p = 0; p < 256; p++)
        begin
            kb   = key_mem[k[7:0]];
            hash = {hash[0], hash[7:1]};
            if (first)
                accum = accum + (hash[0] ? 8'd3 : 8'd2) * kb;
            if (hash == kb)
            begin
                // Only the first match is checked; with no byte after the last
                // key position the checksum must come out as zero.
                if (first)
                begin
                    nxt = (k < 255) ? key_mem[k[7:0] + 8'd1] : 8'h00;
                    if (accum != nxt)
                        return 1'b0;
                end
                hash  = {seed_reg[0], seed_reg[7:1]};
                k     = 0;
                first = 1'b0;
            end
            jj            = jj + (hash ^ key_mem[k[7:0]]) + base_perm[p];
            tmp           = base_perm[p];
            base_perm[p]  = base_perm[jj];
            base_perm[jj] = tmp;
            k++;
        end
        perm_ready = 1'b1;
        return 1'b1;
    endfunction

    // Expected result of one input transaction; updates the mirrored state.
    function automatic rc4v_pkg::res_item_t compute_result(input rc4v_pkg::cmd_item_t it);
        rc4v_pkg::res_item_t r;
        logic [7:0]          tmp;
        int                  p;
        r.data_out = 8'h00;
        r.status   = rc4v_pkg::STATUS_OK;
        case (it.command)
            rc4v_pkg::CMD_LOAD:
            begin
                key_mem[it.key_index] = it.value;
                load_count++;
            end
            rc4v_pkg::CMD_BUILD:
            begin
                build_count++;
                if (run_key_schedule())
                    build_pass_count++;
                else
                    r.status = rc4v_pkg::STATUS_BUILD_FAIL;
            end
            rc4v_pkg::CMD_DECODE:
            begin
                decode_count++;
                if (!perm_ready)
                    r.status = rc4v_pkg::STATUS_INVALID;
                else
                begin
                    if (it.chunk_start)
                    begin
                        for (p = 0; p < 256; p++)
                            work_perm[p] = base_perm[p];
                        ks_i       = 8'h00;
                        ks_j       = 8'h00;
                        work_ready = 1'b1;
                        restart_count++;
                    end
                    ks_i            = ks_i + 8'd1;
                    ks_j            = ks_j + work_perm[ks_i];
                    tmp             = work_perm[ks_i];
                    work_perm[ks_i] = work_perm[ks_j];
                    work_perm[ks_j] = tmp;
                    tmp             = work_perm[ks_i] + work_perm[ks_j];
                    r.data_out      = it.value ^ work_perm[tmp];
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic rc4v_pkg::cmd_item_t load_item(input logic [7:0] idx,
                                                      input logic [7:0] v);
        rc4v_pkg::cmd_item_t it;
        it.command     = rc4v_pkg::CMD_LOAD;
        it.key_index   = idx;
        it.value       = v;
        it.chunk_start = 1'($urandom_range(1));
        return it;
    endfunction

    // A decode may not read the working table before a chunk start has filled it.
    function automatic rc4v_pkg::cmd_item_t decode_item(input logic [7:0] v, input logic cs);
        rc4v_pkg::cmd_item_t it;
        it.command     = rc4v_pkg::CMD_DECODE;
        it.key_index   = 8'($urandom);
        it.value       = v;
        it.chunk_start = cs | (perm_ready & ~work_ready);
        return it;
    endfunction

    // Offer one input transaction, with random idle cycles ahead of it. Called and
    // left at a falling edge, with valid still high.
    task automatic send_item(input rc4v_pkg::cmd_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            cmd_item  <= ITEM_W'($urandom);
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= it;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        pending_results.push_back(compute_result(it));
        if (it.command != CMD_UNUSED)
            item_count++;
        @(negedge clk);
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic wait_idle();
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Read the seed register back and compare it with the mirrored value.
    task automatic check_seed();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= SEED_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[7:0] !== seed_reg)
        begin
            error_count++;
            $display("%0t: seed readback mismatch, expected %02h, actual %02h",
                     $time, seed_reg, prdata[7:0]);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_seed(input logic [7:0] v);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SEED_ADDR;
        pwdata  <= {24'h000000, v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        seed_reg = v;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        check_seed();
    endtask

    // Reshape the key store so that the first hash match falls at match_pos (or never)
    // with a checksum that passes or fails as asked, load the changed bytes and build.
    task automatic schedule_key(input int match_pos, input bit want_pass, input int churn);
        logic [7:0] plan [256];
        logic [7:0] hseq [256];
        logic [7:0] hash;
        logic [7:0] accum;
        logic [7:0] v;
        logic [7:0] trial;
        int         p;
        int         q;
        int         w;
        int         start;
        int         fix_end;
        bit         fixed;
        plan = key_mem;
        repeat (churn) plan[$urandom_range(255)] = 8'($urandom);
        hash = seed_reg;
        for (p = 0; p < 256; p++)
        begin
            hash    = {hash[0], hash[7:1]};
            hseq[p] = hash;
        end
        // Break accidental matches ahead of the wanted one.
        fix_end = (match_pos == NO_MATCH) ? 255 : match_pos - 1;
        for (p = 0; p <= fix_end; p++)
            if (plan[p] == hseq[p])
                plan[p] = plan[p] ^ 8'h01;
        if (match_pos != NO_MATCH)
        begin
            plan[match_pos] = hseq[match_pos];
            accum = seed_reg;
            for (p = 0; p <= match_pos; p++)
                accum = accum + (hseq[p][0] ? 8'd3 : 8'd2) * plan[p];
            if (match_pos < 255)
                plan[match_pos + 1] = want_pass ? accum : accum ^ 8'($urandom_range(1, 255));
            else if ((accum == 8'h00) != want_pass)
            begin
                // At the last key position the checksum is held against zero:
                // steer it by changing one earlier byte without making a match there.
                fixed = 1'b0;
                start = $urandom_range(254);
                for (q = 0; q < 255 && !fixed; q++)
                begin
                    p = (start + q) % 255;
                    for (w = 0; w < 256 && !fixed; w++)
                    begin
                        v     = w[7:0];
                        trial = accum + (hseq[p][0] ? 8'd3 : 8'd2) * (v - plan[p]);
                        if (v != hseq[p] && ((trial == 8'h00) == want_pass))
                        begin
                            plan[p] = v;
                            fixed   = 1'b1;
                        end
                    end
                end
            end
        end
        for (p = 0; p < 256; p++)
            if (plan[p] != key_mem[p])
                send_item(load_item(p[7:0], plan[p]));
        send_item(rc4v_pkg::cmd_item_t'{rc4v_pkg::CMD_BUILD, 8'($urandom), 8'($urandom),
                                        1'($urandom_range(1))});
    endtask

    // A chunk of decode transactions that restarts the keystream on its first byte.
    task automatic decode_run(input int len);
        int n;
        for (n = 0; n < len; n++)
            send_item(decode_item(8'($urandom), (n == 0) || ($urandom_range(19) == 0)));
    endtask

    // Before any table exists: decodes report an invalid table, unused command is inert.
    task automatic test_reset_state();
        check_seed();
        send_item(decode_item(8'hFF, 1'b0));
        send_item(decode_item(8'h00, 1'b1));
        send_item(rc4v_pkg::cmd_item_t'{CMD_UNUSED, 8'hFF, 8'hFF, 1'b1});
        send_item(rc4v_pkg::cmd_item_t'{CMD_UNUSED, 8'h00, 8'h00, 1'b0});
    endtask

    // Fill the whole key store so that every later build reads written bytes.
    task automatic test_key_fill();
        int p;
        for (p = 0; p < 256; p++)
            send_item(load_item(p[7:0], (p == 0) ? 8'h00 : (p == 255) ? 8'hFF : 8'($urandom)));
    endtask

    // Key schedule corners at both extreme seeds.
    task automatic test_schedule();
        write_seed(8'h00);
        // A failed first build leaves the table invalid.
        schedule_key(3, 1'b0, 0);
        send_item(decode_item(8'h5A, 1'b1));
        schedule_key(NO_MATCH, 1'b1, 2);
        schedule_key(10, 1'b1, 2);
        write_seed(8'hFF);
        schedule_key(255, 1'b1, 0);
        schedule_key(255, 1'b0, 0);
        schedule_key(254, 1'b1, 0);
    endtask

    // Keystream start, continuation, and decoding across a failed rebuild.
    task automatic test_decode();
        int n;
        send_item(decode_item(8'h00, 1'b1));
        send_item(decode_item(8'hFF, 1'b0));
        for (n = 0; n < 6; n++)
            send_item(decode_item(8'($urandom), 1'b0));
        // The failed build resets the base table and reshuffles only part of it, but keeps it valid.
        schedule_key(5, 1'b0, 1);
        send_item(decode_item(8'hFF, 1'b0));
        send_item(decode_item(8'h00, 1'b1));
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        write_seed(8'($urandom));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        schedule_key($urandom_range(60), 1'b1, 4);
        hold_off_pending = 1'b1;
        decode_run(30);
        wait_idle();
    endtask

    // Random traffic: mostly decode chunks, plus key rebuilds and noise.
    task automatic test_random_traffic();
        int idle_mix  [4] = '{0, 67, 0, 14};
        int stall_mix [4] = '{0, 0, 67, 14};
        int phase;
        int start;
        int r;
        int m;
        rc4v_pkg::cmd_item_t it;
        for (phase = 0; phase < 4; phase++)
        begin
            write_seed(8'($urandom));
            send_idle_pct  = idle_mix[phase];
            recv_stall_pct = stall_mix[phase];
            start = item_count;
            while (item_count - start < PHASE_ITEMS)
            begin
                r = $urandom_range(99);
                if (r < 20)
                begin
                    r = $urandom_range(9);
                    if (r < 3)
                        m = NO_MATCH;
                    else if (r < 8)
                        m = $urandom_range(40);
                    else if (r == 8)
                        m = 255;
                    else
                        m = $urandom_range(254, 200);
                    schedule_key(m, $urandom_range(99) < 85, $urandom_range(6));
                end
                else if (r < 75)
                    decode_run($urandom_range(40, 1));
                else
                begin
                    it = ITEM_W'($urandom);
                    if (it.command == rc4v_pkg::CMD_BUILD && $urandom_range(3) != 0)
                        it.command = rc4v_pkg::CMD_DECODE;
                    if (it.command == rc4v_pkg::CMD_DECODE && perm_ready && !work_ready)
                        it.chunk_start = 1'b1;
                    send_item(it);
                end
            end
        end
        wait_idle();
    endtask

    // Receiver side: random stalls, or one long hold-off counted here.
    initial
    begin : receiver_side
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                hold_left        = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare each accepted result transaction with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        rc4v_pkg::res_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual data %02h status %0d",
                             $time, res_item.data_out, res_item.status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_item.data_out !== want.data_out)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: data_out mismatch, expected %02h, actual %02h",
                                 $time, want.data_out, res_item.data_out);
                end
                if (res_item.status !== want.status)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, res_item.status);
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd_item  = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_key_fill();
        test_schedule();
        test_decode();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run covered %0d transactions: %0d key loads, %0d builds (%0d completed),",
                 item_count, load_count, build_count, build_pass_count);
        $display("%0d decodes with %0d keystream restarts, under four idle mixes and a hold-off.",
                 decode_count, restart_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
